[src/byte_cipher_checksum_engine_unit_assert.svh]
// Assertion macros for the byte cipher / checksum engine.
// Used by the port checker; needs clk and rst_n in the including scope.
`ifndef BYTE_CIPHER_CHECKSUM_ENGINE_UNIT_ASSERT_SVH
`define BYTE_CIPHER_CHECKSUM_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BCCE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BCCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bcce_pkg.sv]
// Package for the byte cipher / checksum engine: item types, codes, constants.
// No dependencies.
package bcce_pkg;

    localparam int KEY_BYTES = 8;

    localparam logic [7:0]  CIPHER_OFFSET      = 8'hAB;
    localparam logic [7:0]  BLOCK_LENGTH_RESET = 8'd17;
    localparam logic [63:0] SESSION_KEY_RESET  = 64'd0;

    // Action codes
    localparam logic [2:0] ACT_COPY     = 3'd0;
    localparam logic [2:0] ACT_COMPARE  = 3'd1;
    localparam logic [2:0] ACT_MIX      = 3'd2;
    localparam logic [2:0] ACT_ENCRYPT  = 3'd3;
    localparam logic [2:0] ACT_DECRYPT  = 3'd4;
    localparam logic [2:0] ACT_CHECKSUM = 3'd5;

    // Register indexes
    localparam int REG_IDX_W = 4;
    localparam logic [REG_IDX_W-1:0] REG_SESSION_KEY  = 4'd0;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_LENGTH = 4'd1;

    typedef struct packed {
        logic [2:0] action;
        logic       first;
        logic [7:0] source_byte;
        logic [7:0] dest_byte;
        logic [7:0] timer_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       all_equal;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0] reg_index;
        logic [63:0]          write_data;
    } cfg_write_t;

    typedef struct packed {
        logic [63:0] session_key;
        logic [7:0]  block_length;
    } cfg_t;

endpackage

[src/bcce_chan_if.sv]
// Valid/ready channel carrying one payload item.
// Payload type is given by the instantiating scope (see bcce_pkg).
interface bcce_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/bcce_cfg_regs.sv]
// Configuration register file: session key and block length.
// Depends on bcce_pkg and bcce_chan_if.
module bcce_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    bcce_chan_if.sink      cfg,
    output bcce_pkg::cfg_t regs
);

    logic [63:0] session_key_reg;
    logic [63:0] session_key_next;
    logic [7:0]  block_length_reg;
    logic [7:0]  block_length_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        session_key_next  = session_key_reg;
        block_length_next = block_length_reg;
        if (cfg.valid)
        begin
            unique case (cfg.data.reg_index)
                bcce_pkg::REG_SESSION_KEY:  session_key_next  = cfg.data.write_data;
                bcce_pkg::REG_BLOCK_LENGTH: block_length_next = cfg.data.write_data[7:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_key_reg  <= bcce_pkg::SESSION_KEY_RESET;
            block_length_reg <= bcce_pkg::BLOCK_LENGTH_RESET;
        end
        else
        begin
            session_key_reg  <= session_key_next;
            block_length_reg <= block_length_next;
        end
    end

    assign regs.session_key  = session_key_reg;
    assign regs.block_length = block_length_reg;

endmodule

[src/bcce_datapath.sv]
// Per-byte datapath: run state (count, key index, match flag, accumulator)
// and the result logic for all actions. Depends on bcce_pkg.
module bcce_datapath #(
    parameter int KeyBytes = bcce_pkg::KEY_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  bcce_pkg::item_t   item,
    input  bcce_pkg::cfg_t    regs,
    output bcce_pkg::result_t result
);

    localparam int KeyIdxW = (KeyBytes > 1) ? $clog2(KeyBytes) : 1;
    localparam logic [KeyIdxW-1:0] KeyIdxLast = KeyIdxW'(KeyBytes - 1);

    logic [7:0]         count_reg;
    logic [7:0]         count_next;
    logic [KeyIdxW-1:0] key_idx_reg;
    logic [KeyIdxW-1:0] key_idx_next;
    logic               match_reg;
    logic               match_next;
    logic [7:0]         acc_reg;
    logic [7:0]         acc_next;

    logic [7:0]         cnt;
    logic [KeyIdxW-1:0] key_idx;
    logic [KeyIdxW-1:0] key_idx_adv;
    logic               match_cur;
    logic [7:0]         acc_cur;
    logic [7:0]         key_byte;
    logic [7:0]         res;
    logic               eq;

    // A first item restarts the run before the byte is processed
    assign cnt       = item.first ? regs.block_length : count_reg;
    assign key_idx   = item.first ? '0 : key_idx_reg;
    assign match_cur = item.first ? 1'b1 : match_reg;
    assign acc_cur   = item.first ? item.dest_byte : acc_reg;

    assign key_byte    = regs.session_key[{key_idx, 3'b000} +: 8];
    assign key_idx_adv = (key_idx == KeyIdxLast) ? '0 : key_idx + KeyIdxW'(1);

    always_comb
    begin
        res          = item.dest_byte;
        eq           = 1'b0;
        key_idx_next = key_idx;
        match_next   = match_cur;
        acc_next     = acc_cur;
        unique case (item.action)
            bcce_pkg::ACT_COPY:
                res = item.source_byte;
            bcce_pkg::ACT_COMPARE:
            begin
                match_next = match_cur & (item.source_byte == item.dest_byte);
                eq         = match_next;
            end
            bcce_pkg::ACT_MIX:
                res = 8'(item.dest_byte + item.timer_byte) ^ item.source_byte;
            bcce_pkg::ACT_ENCRYPT:
            begin
                res = 8'(item.dest_byte + bcce_pkg::CIPHER_OFFSET) ^ cnt ^ key_byte;
                key_idx_next = key_idx_adv;
            end
            bcce_pkg::ACT_DECRYPT:
            begin
                res = 8'((item.dest_byte ^ key_byte ^ cnt) - bcce_pkg::CIPHER_OFFSET);
                key_idx_next = key_idx_adv;
            end
            bcce_pkg::ACT_CHECKSUM:
            begin
                acc_next = 8'(acc_cur + item.source_byte);
                res      = acc_next;
            end
            default:
                ;
        endcase
    end

    // Count sticks at zero once exhausted
    assign count_next = (cnt != 8'd0) ? 8'(cnt - 8'd1) : cnt;

    assign result.result_byte = res;
    assign result.all_equal   = eq;
    assign result.last        = (cnt == 8'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 8'd0;
            key_idx_reg <= '0;
            match_reg   <= 1'b1;
            acc_reg     <= 8'd0;
        end
        else if (step)
        begin
            count_reg   <= count_next;
            key_idx_reg <= key_idx_next;
            match_reg   <= match_next;
            acc_reg     <= acc_next;
        end
    end

endmodule

[src/byte_cipher_checksum_engine_unit.sv]
// Byte cipher / checksum engine: input register, datapath, result register.
// An accepted item passes through the input register, then the result register, before its result is offered.
// Throughput: one item per cycle; the input register and the result register
// form a two-deep pipeline, so a held result stalls input only once both are full.
// Reset (rst_n, async, low): pipeline empty, run state cleared, key 0, block length 17.
module byte_cipher_checksum_engine_unit #(
    parameter int KeyBytes = bcce_pkg::KEY_BYTES
) (
    input  logic         clk,
    input  logic         rst_n,
    bcce_chan_if.sink    items,
    bcce_chan_if.source  results,
    bcce_chan_if.sink    cfg
);

    bcce_pkg::cfg_t    regs;
    bcce_pkg::item_t   in_item_reg;
    bcce_pkg::result_t result_comb;
    bcce_pkg::result_t out_result_reg;

    logic in_valid_reg;
    logic in_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic in_accept;
    logic step;

    bcce_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    bcce_datapath #(
        .KeyBytes (KeyBytes)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .regs   (regs),
        .result (result_comb)
    );

    // Item moves on when the result register is empty or being drained
    assign step      = in_valid_reg && (!out_valid_reg || results.ready);
    assign in_accept = items.valid && items.ready;

    assign items.ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_item_reg <= items.data;
        if (step)
            out_result_reg <= result_comb;
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_result_reg;

endmodule

[src/bcce_port_checker.sv]
// Port-level checks for the byte cipher / checksum engine, bound to the top level.
// Depends on bcce_pkg and byte_cipher_checksum_engine_unit_assert.svh.
`include "byte_cipher_checksum_engine_unit_assert.svh"

module bcce_port_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              items_valid,
    input logic              items_ready,
    input logic              results_valid,
    input logic              results_ready,
    input bcce_pkg::result_t results_data
);

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = items_valid && items_ready;
    assign out_fire = results_valid && results_ready;

    // Items taken in but not yet delivered
    assign inflight_next = 2'(inflight_reg + {1'b0, in_fire} - {1'b0, out_fire});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 2'd0;
        else
            inflight_reg <= inflight_next;
    end

    `BCCE_ASSERT_NOW(a_no_spurious_result, inflight_reg == 2'd0, !results_valid,
        "result offered with no item in flight")
    `BCCE_ASSERT_NOW(a_ready_when_empty, inflight_reg == 2'd0, items_ready,
        "input stalled while block is empty")
    `BCCE_ASSERT_NOW(a_two_deep, (inflight_reg == 2'd2) && !results_ready, !items_ready,
        "item accepted beyond pipeline depth")
    `BCCE_ASSERT_NEXT(a_result_held, results_valid && !results_ready,
        results_valid && $stable(results_data), "stalled result changed or dropped")

endmodule

bind byte_cipher_checksum_engine_unit bcce_port_checker u_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .items_valid   (items.valid),
    .items_ready   (items.ready),
    .results_valid (results.valid),
    .results_ready (results.ready),
    .results_data  (results.data)
);
